/* rtl/lpmd_pkg.sv */
package lpmd_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_HALTED  = 2'd2;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_EMPTY  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_LINK   = 2'd3;

  localparam logic [15:0] LEN_LIMIT_RST = 16'd2048;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] msg_id;
    logic [15:0] msg_len;
    logic [7:0]  payload_byte;
    logic        last;
  } word_t;

endpackage

/* rtl/lpmd_front.sv */
module lpmd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_link_error,
  input  logic [15:0]         len_limit,
  input  logic                q_full,
  output logic                q_push,
  output lpmd_pkg::word_t     q_word
);
  import lpmd_pkg::*;

  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] len_full;
  logic [15:0] left_dec;
  logic        take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign len_full = {len_r[15:8], in_data_byte};
  assign left_dec = left_r - 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    q_push    = 1'b0;
    q_word    = '{kind: KIND_DATA, msg_id: id_r, msg_len: len_r,
                  payload_byte: 8'd0, last: 1'b0};
    if (take && (phase_r == PH_HEADER || phase_r == PH_PAYLOAD)) begin
      if (in_link_error) begin
        q_push       = 1'b1;
        q_word.kind  = KIND_LINK;
        phase_nxt    = PH_HALTED;
      end else if (phase_r == PH_HEADER) begin
        case (hcnt_r)
          2'd0: begin
            id_nxt   = {in_data_byte, 8'd0};
            hcnt_nxt = 2'd1;
          end
          2'd1: begin
            id_nxt   = {id_r[15:8], in_data_byte};
            hcnt_nxt = 2'd2;
          end
          2'd2: begin
            len_nxt  = {in_data_byte, 8'd0};
            hcnt_nxt = 2'd3;
          end
          default: begin
            len_nxt        = len_full;
            hcnt_nxt       = 2'd0;
            q_word.msg_len = len_full;
            if (id_r > len_limit || len_full > len_limit) begin
              q_push      = 1'b1;
              q_word.kind = KIND_REJECT;
              phase_nxt   = PH_HALTED;
            end else if (len_full == 16'd0) begin
              q_push      = 1'b1;
              q_word.kind = KIND_EMPTY;
            end else begin
              left_nxt  = len_full;
              phase_nxt = PH_PAYLOAD;
            end
          end
        endcase
      end else begin
        left_nxt            = left_dec;
        q_push              = 1'b1;
        q_word.payload_byte = in_data_byte;
        q_word.last         = (left_dec == 16'd0);
        if (left_dec == 16'd0) begin
          phase_nxt = PH_HEADER;
          hcnt_nxt  = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hcnt_r  <= 2'd0;
      id_r    <= 16'd0;
      len_r   <= 16'd0;
      left_r  <= 16'd0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

/* rtl/lpmd_fifo.sv */
module lpmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lpmd_pkg::word_t push_word,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output lpmd_pkg::word_t pop_word
);
  import lpmd_pkg::*;

  word_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_word = mem[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + PTR_W'(1) : wptr_r;
    rptr_nxt = do_pop ? rptr_r + PTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

/* rtl/lpmd_back.sv */
module lpmd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  lpmd_pkg::word_t q_word,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_kind,
  output logic [15:0]     out_msg_id,
  output logic [15:0]     out_msg_len,
  output logic [7:0]      out_payload_byte,
  output logic            out_last
);
  import lpmd_pkg::*;

  logic  valid_r, valid_nxt;
  word_t word_r;

  assign q_pop     = !q_empty && (!valid_r || out_ready);
  assign valid_nxt = q_pop || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      word_r <= q_word;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = word_r.kind;
  assign out_msg_id       = word_r.msg_id;
  assign out_msg_len      = word_r.msg_len;
  assign out_payload_byte = word_r.payload_byte;
  assign out_last         = word_r.last;

endmodule

/* rtl/length_prefixed_message_deframer_top.sv */
// Length-prefixed message deframer.
// Input channel: one stream byte per word (in_data_byte, in_link_error),
// valid/ready. Each message is a 4-byte big-endian header (16-bit id,
// 16-bit length) followed by that many payload bytes.
// Output channel: at most one word per input byte: a payload byte with id,
// length and last flag, an empty-message word, a header-reject word or a
// link-failure word. A header yields a word only on its last byte (empty
// or reject); after a reject or link failure bytes are dropped until reset.
// Configuration: APB register at address 0 holds the limit for id and
// length (reset 2048); write it only while the block is idle.
// Throughput: one input byte per cycle while the queue is not full.
// Each word is written into the 4-entry queue when its byte is accepted,
// and the queue loads the output register when that register is empty
// or its word is being taken.
// Reset (synchronous, rst_n low) clears the parser, the queue and the
// output valid flag. When the receiver stalls, the output register holds,
// the queue fills, and in_ready drops once the queue is full.
module length_prefixed_message_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_link_error,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_msg_id,
  output logic [15:0] out_msg_len,
  output logic [7:0]  out_payload_byte,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lpmd_pkg::*;

  logic [15:0] len_limit_r;
  logic        q_full, q_push, q_empty, q_pop;
  word_t       push_word, pop_word;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, len_limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_limit_r <= LEN_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      len_limit_r <= pwdata[15:0];
    end
  end

  lpmd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_link_error (in_link_error),
    .len_limit     (len_limit_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_word        (push_word)
  );

  lpmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_word  (pop_word)
  );

  lpmd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_word           (pop_word),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_msg_id       (out_msg_id),
    .out_msg_len      (out_msg_len),
    .out_payload_byte (out_payload_byte),
    .out_last         (out_last)
  );

endmodule

/* bench/length_prefixed_message_deframer_top_tb.sv */
`timescale 1ns / 100ps

module length_prefixed_message_deframer_top_tb;
  import lpmd_pkg::*;

  localparam logic [2:0] ADDR_LEN_LIMIT = 3'd0;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned N_PHASES = 6;
  localparam int unsigned BYTES_PER_PHASE = 180;
  localparam word_t NO_WORD = '0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       link_error;
    bit         fixed;
    word_t      word;
  } stim_row_t;

  localparam int unsigned N_ROWS = 22;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_link_error = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [15:0] out_msg_id;
  logic [15:0] out_msg_len;
  logic [7:0]  out_payload_byte;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = ADDR_LEN_LIMIT;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [15:0] lim_len = LEN_LIMIT_RST;
  logic [1:0]  prd_phase = PH_HEADER;
  logic [1:0]  prd_hdr_cnt = 2'd0;
  logic [15:0] prd_id = 16'h0;
  logic [15:0] prd_len = 16'h0;
  logic [15:0] prd_left = 16'h0;

  word_t       pending_words[$];
  word_t       want;
  int unsigned n_err = 0;
  int unsigned n_bytes = 0;
  int unsigned cyc = 0;
  int unsigned stall_left = 0;
  bit          idle_en = 1'b1;

  stim_row_t dir_tab [0:N_ROWS-1] = '{
    {8'h00, 1'b0, 1'b0, NO_WORD},
    {8'h00, 1'b0, 1'b0, NO_WORD},
    {8'h00, 1'b0, 1'b0, NO_WORD},
    {8'h00, 1'b0, 1'b1, {KIND_EMPTY, 16'h0000, 16'h0000, 8'h00, 1'b0}},
    {8'h08, 1'b0, 1'b0, NO_WORD},
    {8'h00, 1'b0, 1'b0, NO_WORD},
    {8'h00, 1'b0, 1'b0, NO_WORD},
    {8'h01, 1'b0, 1'b0, NO_WORD},
    {8'hFF, 1'b0, 1'b1, {KIND_DATA, 16'h0800, 16'h0001, 8'hFF, 1'b1}},
    {8'h00, 1'b0, 1'b0, NO_WORD},
    {8'h01, 1'b0, 1'b0, NO_WORD},
    {8'h00, 1'b0, 1'b0, NO_WORD},
    {8'h03, 1'b0, 1'b0, NO_WORD},
    {8'h00, 1'b0, 1'b0, NO_WORD},
    {8'h80, 1'b0, 1'b0, NO_WORD},
    {8'h7F, 1'b0, 1'b0, NO_WORD},
    {8'h07, 1'b0, 1'b0, NO_WORD},
    {8'hFF, 1'b0, 1'b0, NO_WORD},
    {8'h00, 1'b0, 1'b0, NO_WORD},
    {8'h02, 1'b0, 1'b0, NO_WORD},
    {8'h55, 1'b0, 1'b0, NO_WORD},
    {8'hAA, 1'b0, 1'b0, NO_WORD}
  };

  length_prefixed_message_deframer_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_link_error    (in_link_error),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_msg_id       (out_msg_id),
    .out_msg_len      (out_msg_len),
    .out_payload_byte (out_payload_byte),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic bit deframe_byte(input logic [7:0] d, input logic e, output word_t w);
    w = '0;
    w.msg_id = prd_id;
    w.msg_len = prd_len;
    if (prd_phase != PH_HEADER && prd_phase != PH_PAYLOAD) return 1'b0;
    if (e) begin
      w.kind = KIND_LINK;
      prd_phase = PH_HALTED;
      return 1'b1;
    end
    if (prd_phase == PH_HEADER) begin
      case (prd_hdr_cnt)
        2'd0: begin
          prd_id = {d, 8'h00};
          prd_hdr_cnt = 2'd1;
          return 1'b0;
        end
        2'd1: begin
          prd_id[7:0] = d;
          prd_hdr_cnt = 2'd2;
          return 1'b0;
        end
        2'd2: begin
          prd_len = {d, 8'h00};
          prd_hdr_cnt = 2'd3;
          return 1'b0;
        end
        default: begin
          prd_len[7:0] = d;
          prd_hdr_cnt = 2'd0;
        end
      endcase
      w.msg_id = prd_id;
      w.msg_len = prd_len;
      if (prd_id > lim_len || prd_len > lim_len) begin
        w.kind = KIND_REJECT;
        prd_phase = PH_HALTED;
        return 1'b1;
      end
      if (prd_len == 16'h0) begin
        w.kind = KIND_EMPTY;
        return 1'b1;
      end
      prd_left = prd_len;
      prd_phase = PH_PAYLOAD;
      return 1'b0;
    end
    prd_left = prd_left - 16'd1;
    w.kind = KIND_DATA;
    w.payload_byte = d;
    w.last = (prd_left == 16'h0);
    if (w.last) begin
      prd_phase = PH_HEADER;
      prd_hdr_cnt = 2'd0;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_err++;
    end
  endfunction

  // receiver: random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: kind %0h id %0h len %0h", out_kind, out_msg_id, out_msg_len);
        n_err++;
      end else begin
        want = pending_words.pop_front();
        check_field("kind", 16'(want.kind), 16'(out_kind));
        check_field("msg_id", want.msg_id, out_msg_id);
        check_field("msg_len", want.msg_len, out_msg_len);
        check_field("payload_byte", 16'(want.payload_byte), 16'(out_payload_byte));
        check_field("last", 16'(want.last), 16'(out_last));
      end
    end
  end

  task automatic push_byte(input logic [7:0] d, input logic e, input bit use_fix,
                           input word_t fix_w);
    word_t w;
    bit    has;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_link_error <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has = deframe_byte(d, e, w);
    if (use_fix) pending_words.push_back(fix_w);
    else if (has) pending_words.push_back(w);
    n_bytes++;
  endtask

  function automatic logic [7:0] rand_payload();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic push_header(input logic [15:0] id, input logic [15:0] len);
    push_byte(id[15:8], 1'b0, 1'b0, NO_WORD);
    push_byte(id[7:0], 1'b0, 1'b0, NO_WORD);
    push_byte(len[15:8], 1'b0, 1'b0, NO_WORD);
    push_byte(len[7:0], 1'b0, 1'b0, NO_WORD);
  endtask

  task automatic push_msg(input logic [15:0] id, input logic [15:0] len);
    push_header(id, len);
    for (int i = 0; i < int'(len); i++) push_byte(rand_payload(), 1'b0, 1'b0, NO_WORD);
  endtask

  // drop valid and wait for the block to drain
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_LEN_LIMIT;
    pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    lim_len = v;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("len_limit", v, prdata[15:0]);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0]  lims [N_PHASES];
    logic [15:0]  id;
    logic [15:0]  len;
    int unsigned  r;
    int unsigned  k;
    int unsigned  target;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++)
      push_byte(dir_tab[i].data_byte, dir_tab[i].link_error, dir_tab[i].fixed, dir_tab[i].word);
    settle();

    lims[0] = 16'hFFFF;
    lims[1] = 16'h0000;
    lims[2] = 16'($urandom_range(1, 64));
    lims[3] = 16'($urandom);
    lims[4] = 16'd1;
    lims[5] = 16'($urandom_range(16, 4096));

    for (int p = 0; p < N_PHASES; p++) begin
      if (p == N_PHASES - 1) idle_en = 1'b0;
      set_limit(lims[p]);
      target = n_bytes + BYTES_PER_PHASE;
      while (n_bytes < target) begin
        r = $urandom_range(0, 7);
        id = (r == 0) ? 16'h0 : (r == 1) ? lim_len : 16'($urandom_range(0, lim_len));
        r = $urandom_range(0, 15);
        if (r == 0) len = 16'h0;
        else if (r == 1) len = 16'($urandom_range(40, 200));
        else len = 16'($urandom_range(1, 8));
        if (len > lim_len) len = lim_len;
        push_msg(id, len);
      end
      if (p != N_PHASES - 1) settle();
    end

    // halt the block: link failure or rejected header
    case ($urandom_range(0, 3))
      0: begin
        k = $urandom_range(0, 3);
        for (int i = 0; i < int'(k); i++) push_byte(8'($urandom), 1'b0, 1'b0, NO_WORD);
        push_byte(8'($urandom), 1'b1, 1'b0, NO_WORD);
      end
      1: begin
        len = 16'($urandom_range(2, 16));
        push_header(16'($urandom_range(0, lim_len)), len);
        k = $urandom_range(0, len - 1);
        for (int i = 0; i < int'(k); i++) push_byte(rand_payload(), 1'b0, 1'b0, NO_WORD);
        push_byte(8'($urandom), 1'b1, 1'b0, NO_WORD);
      end
      2: push_header(16'($urandom_range(lim_len + 1, 65535)),
                     16'($urandom_range(0, lim_len)));
      default: push_header(16'($urandom_range(0, lim_len)),
                           16'($urandom_range(lim_len + 1, 65535)));
    endcase
    for (int i = 0; i < 24; i++) push_byte(8'($urandom), 1'($urandom), 1'b0, NO_WORD);
    in_valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/lpmd_pkg.sv
rtl/lpmd_front.sv
rtl/lpmd_fifo.sv
rtl/lpmd_back.sv
rtl/length_prefixed_message_deframer_top.sv
bench/length_prefixed_message_deframer_top_tb.sv
